@@ rtl/core/calendar_date_entry_stepper_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the date entry stepper.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ENTRY_STEPPER_UNIT_ASSERT_SVH
`define CALENDAR_DATE_ENTRY_STEPPER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define CDES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define CDES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define CDES_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CDES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/cdes_pkg.sv @@
// ----------------------------------------------------------------------------
// Date entry stepper package
// Field widths, command and status codes, control types and month lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package cdes_pkg;

  localparam int CMD_W    = 3;
  localparam int YEAR_W   = 7;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int STATUS_W = 2;
  localparam int GROWTH_W = 17;
  localparam int GROWTH_SHIFT = 16;

  localparam logic [GROWTH_W-1:0] GROWTH_NUM = 17'd68813;

  localparam logic [CMD_W-1:0] CMD_IDLE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ACCEPT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_EDITING   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ACCEPTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_CANCELLED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_REJECTED  = 2'd3;

  localparam logic [YEAR_W-1:0]  TOP_YEAR   = 7'd99;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
  localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;
  localparam logic [DAY_W-1:0]   MAX_STEP_RESET = 5'd30;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic grow_en;
    logic step_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [DAY_W-1:0] walk_days;
  } dp_status_t;

  // Years are offsets from 2000, so within the century a year divisible by
  // four is a leap year, 2000 included.
  function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] yoff,
                                                  input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] days;
    case (month) inside
      4'd2:                    days = (yoff[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      default:                 days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cdes_if.sv @@
// ----------------------------------------------------------------------------
// Date entry stepper channels
// Valid/ready interfaces for the button event and date report channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdes_in_if;
  import cdes_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [YEAR_W-1:0]  load_year;
  logic [MONTH_W-1:0] load_month;
  logic [DAY_W-1:0]   load_day;

  modport source (output valid, command, load_year, load_month, load_day, input ready);
  modport sink (input valid, command, load_year, load_month, load_day, output ready);
endinterface

interface cdes_out_if;
  import cdes_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;

  modport source (output valid, status, out_year, out_month, out_day, input ready);
  modport sink (input valid, status, out_year, out_month, out_day, output ready);
endinterface

`default_nettype wire

@@ rtl/core/calendar_date_entry_stepper_unit.sv @@
// ----------------------------------------------------------------------------
// Calendar date entry stepper
// Edits a date in 2000..2099 from button events with an accelerating step.
// ----------------------------------------------------------------------------
//   Channel   Direction  Carries
//   in_item   sink       command, load_year, load_month, load_day
//   out_item  source     status, out_year, out_month, out_day
//   cfg_*     write      max_step_days
//
// An item is captured, its step grown, the date walked one day per step and
// the report written; the day-by-day walk of the date registers dominates.
// A new item is taken while the previous report still waits in the output
// register; the report of the new item then waits until that one is taken.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_entry_stepper_unit #(
  parameter int STEP_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cdes_in_if.sink                    in_item,
  cdes_out_if.source                 out_item,
  input  logic                       cfg_wr_en,
  input  logic [cdes_pkg::DAY_W-1:0] cfg_wr_data
);
  import cdes_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  cdes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  cdes_datapath #(
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .dp_status     (dp_status),
    .in_command    (in_item.command),
    .in_load_year  (in_item.load_year),
    .in_load_month (in_item.load_month),
    .in_load_day   (in_item.load_day),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_status    (out_item.status),
    .out_year      (out_item.out_year),
    .out_month     (out_item.out_month),
    .out_day       (out_item.out_day)
  );

endmodule

`default_nettype wire

@@ rtl/core/cdes_ctrl.sv @@
// ----------------------------------------------------------------------------
// Date entry stepper controller
// Sequences capture, step growth, the day-by-day walk and the report.
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_date_entry_stepper_unit_assert.svh"

module cdes_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  cdes_pkg::dp_status_t   dp_status,
  output cdes_pkg::ctrl_cmd_t    cmd
);
  import cdes_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_GROW   = 5'b00100,
    S_WALK   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [DAY_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_GROW;
      end
      S_GROW: begin
        cmd.grow_en = 1'b1;
        count_nxt   = dp_status.walk_days;
        state_nxt   = (dp_status.walk_days != '0) ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        cmd.step_en = 1'b1;
        count_nxt   = count_r - DAY_W'(1);
        if (count_r == DAY_W'(1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CDES_ASSERT_IMPL(a_finish_slot_free, clk, rst_n, cmd.finish, !out_valid_r || out_ready)
  `CDES_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_r == S_MUL)
  `CDES_ASSERT_IMPL(a_walk_count, clk, rst_n, state_r == S_WALK, count_r != '0)

endmodule

`default_nettype wire

@@ rtl/core/cdes_datapath.sv @@
// ----------------------------------------------------------------------------
// Date entry stepper datapath
// Holds the date, the step magnitude, the cap and the report register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdes_datapath #(
  parameter int STEP_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cdes_pkg::ctrl_cmd_t            cmd,
  output cdes_pkg::dp_status_t           dp_status,
  input  logic [cdes_pkg::CMD_W-1:0]     in_command,
  input  logic [cdes_pkg::YEAR_W-1:0]    in_load_year,
  input  logic [cdes_pkg::MONTH_W-1:0]   in_load_month,
  input  logic [cdes_pkg::DAY_W-1:0]     in_load_day,
  input  logic                           cfg_wr_en,
  input  logic [cdes_pkg::DAY_W-1:0]     cfg_wr_data,
  output logic [cdes_pkg::STATUS_W-1:0]  out_status,
  output logic [cdes_pkg::YEAR_W-1:0]    out_year,
  output logic [cdes_pkg::MONTH_W-1:0]   out_month,
  output logic [cdes_pkg::DAY_W-1:0]     out_day
);
  import cdes_pkg::*;

  localparam int MAG_W  = DAY_W + STEP_FRAC_BITS;
  localparam int PROD_W = MAG_W + GROWTH_W;
  localparam int GROW_W = MAG_W + 2;

  logic [CMD_W-1:0]    cmd_r;
  logic [YEAR_W-1:0]   ld_year_r;
  logic [MONTH_W-1:0]  ld_month_r;
  logic [DAY_W-1:0]    ld_day_r;
  logic [DAY_W-1:0]    max_step_r;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [MONTH_W-1:0]  month_r, month_nxt;
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic                dir_up_r, dir_up_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [STATUS_W-1:0] status_r;
  logic [YEAR_W-1:0]   rep_year_r;
  logic [MONTH_W-1:0]  rep_month_r;
  logic [DAY_W-1:0]    rep_day_r;

  logic                is_up, is_move, same_dir, load_ok;
  logic [GROW_W-1:0]   grown, cand;
  logic [MAG_W-1:0]    cap, one_mag, mag_new;
  logic [STATUS_W-1:0] status_nxt;
  logic [DAY_W-1:0]    dim_cur, dim_prev;

  assign is_up    = (cmd_r == CMD_UP);
  assign is_move  = is_up || (cmd_r == CMD_DOWN);
  assign same_dir = (mag_r != '0) && (dir_up_r == is_up);
  assign one_mag  = MAG_W'(1) << STEP_FRAC_BITS;
  assign cap      = {max_step_r, {STEP_FRAC_BITS{1'b0}}};
  assign grown    = GROW_W'(prod_r >> GROWTH_SHIFT) + (GROW_W'(1) << (STEP_FRAC_BITS - 1));
  assign cand     = same_dir ? grown : GROW_W'(one_mag);
  assign mag_new  = (cand > GROW_W'(cap)) ? cap : MAG_W'(cand);

  assign dp_status.walk_days = is_move ? mag_new[MAG_W-1 -: DAY_W] : '0;

  assign dim_cur  = month_days(year_r, month_r);
  assign dim_prev = month_days(year_r, month_r - MONTH_W'(1));
  assign load_ok  = (ld_year_r <= TOP_YEAR) && (ld_month_r != '0) &&
                    (ld_month_r <= LAST_MONTH) && (ld_day_r != '0) &&
                    (ld_day_r <= month_days(ld_year_r, ld_month_r));

  always_comb begin
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    mag_nxt    = mag_r;
    dir_up_nxt = dir_up_r;
    status_nxt = STAT_EDITING;
    if (cmd.grow_en && is_move) begin
      mag_nxt    = mag_new;
      dir_up_nxt = is_up;
    end
    if (cmd.step_en) begin
      if (is_up) begin
        if (day_r < dim_cur) begin
          day_nxt = day_r + DAY_W'(1);
        end else if (month_r < LAST_MONTH) begin
          month_nxt = month_r + MONTH_W'(1);
          day_nxt   = DAY_W'(1);
        end else if (year_r < TOP_YEAR) begin
          year_nxt  = year_r + YEAR_W'(1);
          month_nxt = MONTH_W'(1);
          day_nxt   = DAY_W'(1);
        end
      end else begin
        if (day_r > DAY_W'(1)) begin
          day_nxt = day_r - DAY_W'(1);
        end else if (month_r > MONTH_W'(1)) begin
          month_nxt = month_r - MONTH_W'(1);
          day_nxt   = dim_prev;
        end else if (year_r != '0) begin
          year_nxt  = year_r - YEAR_W'(1);
          month_nxt = LAST_MONTH;
          day_nxt   = LAST_DAY;
        end
      end
    end
    if (cmd.finish) begin
      case (cmd_r) inside
        CMD_LOAD: begin
          if (load_ok) begin
            year_nxt  = ld_year_r;
            month_nxt = ld_month_r;
            day_nxt   = ld_day_r;
            mag_nxt   = '0;
          end else begin
            status_nxt = STAT_REJECTED;
          end
        end
        CMD_UP, CMD_DOWN: status_nxt = STAT_EDITING;
        CMD_ACCEPT: begin
          status_nxt = STAT_ACCEPTED;
          mag_nxt    = '0;
        end
        CMD_CANCEL: begin
          status_nxt = STAT_CANCELLED;
          mag_nxt    = '0;
        end
        default: mag_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r <= MAX_STEP_RESET;
      year_r     <= '0;
      month_r    <= MONTH_W'(1);
      day_r      <= DAY_W'(1);
      mag_r      <= '0;
      dir_up_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_step_r <= cfg_wr_data;
      end
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      mag_r    <= mag_nxt;
      dir_up_r <= dir_up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r      <= in_command;
      ld_year_r  <= in_load_year;
      ld_month_r <= in_load_month;
      ld_day_r   <= in_load_day;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(GROWTH_NUM);
    end
    if (cmd.finish) begin
      status_r    <= status_nxt;
      rep_year_r  <= year_nxt;
      rep_month_r <= month_nxt;
      rep_day_r   <= day_nxt;
    end
  end

  assign out_status = status_r;
  assign out_year   = rep_year_r;
  assign out_month  = rep_month_r;
  assign out_day    = rep_day_r;

endmodule

`default_nettype wire
